/* rtl/core/blm_pkg.sv */
// Shared constants, codes and types of the block lock manager.
`default_nettype none
package blm_pkg;

   localparam int NUM_PROCS   = 64;
   localparam int PROC_W      = 6;
   localparam int OWN_W       = 7;
   localparam int ENTRIES     = 256;
   localparam int ENTRY_W     = 8;
   localparam int QDEPTH      = 8;
   localparam int QPTR_W      = 3;
   localparam int QCNT_W      = 4;
   localparam int RC_W        = 7;
   localparam logic [RC_W-1:0]  READER_MAX = 7'd127;
   localparam logic [OWN_W-1:0] PROC_NONE  = OWN_W'(NUM_PROCS);
   localparam logic [QCNT_W-1:0] QFULL     = QCNT_W'(QDEPTH);

   localparam logic MODE_LOCK    = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;
   localparam logic K_READ  = 1'b0;
   localparam logic K_WRITE = 1'b1;

   localparam logic [1:0] REL_UNLOCK = 2'd0;
   localparam logic [1:0] REL_SWITCH = 2'd1;
   localparam logic [1:0] REL_RESET  = 2'd2;

   localparam logic [1:0] R_GRANT  = 2'd0;
   localparam logic [1:0] R_QUEUE  = 2'd1;
   localparam logic [1:0] R_REJECT = 2'd2;

   localparam logic [1:0] EM_FREE  = 2'd0;
   localparam logic [1:0] EM_READ  = 2'd1;
   localparam logic [1:0] EM_WRITE = 2'd2;

   typedef struct packed {
      logic               mode;
      logic [PROC_W-1:0]  requester;
      logic [ENTRY_W-1:0] entry;
      logic               lock_kind;
      logic [1:0]         rel_kind;
      logic               bad;
   } cmd_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [PROC_W-1:0]  grantee;
      logic [ENTRY_W-1:0] entry;
      logic [OWN_W-1:0]   owner;
      logic [OWN_W-1:0]   last;
      logic               gkind;
      logic               last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [OWN_W-1:0]  owner;
      logic [OWN_W-1:0]  holder;
      logic [OWN_W-1:0]  last;
      logic [1:0]        emode;
      logic [RC_W-1:0]   readers;
      logic [QCNT_W-1:0] wcount;
      logic [QPTR_W-1:0] whead;
   } rec_type;

   typedef struct packed {
      logic [PROC_W-1:0] proc;
      logic              kind;
   } wait_type;

   typedef struct packed {
      logic [PROC_W-1:0] my_rank;
      logic              mig;
   } cfg_type;

   localparam rec_type REC_RESET = '{owner: PROC_NONE, holder: PROC_NONE,
      last: PROC_NONE, emode: EM_FREE, readers: '0, wcount: '0, whead: '0};

endpackage
`default_nettype wire

/* rtl/core/blm_front.sv */
// Request intake: classifies requests and queues them for the engine.
`default_nettype none
module blm_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire logic             req_mode,
   input  wire logic [5:0]       req_requester,
   input  wire logic [7:0]       req_entry_index,
   input  wire logic             req_lock_kind,
   input  wire logic [1:0]       req_release_kind,
   input  wire logic             cmd_pop,
   output logic                  cmd_empty,
   output blm_pkg::cmd_type      cmd
);
   import blm_pkg::*;

   cmd_type    slot_ff [2];
   logic       wp_ff, rp_ff, wp_in, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cin;
   logic       do_push, do_pop;

   always_comb begin
      cin.mode      = req_mode;
      cin.requester = req_requester;
      cin.entry     = req_entry_index;
      cin.lock_kind = req_lock_kind;
      cin.rel_kind  = req_release_kind;
      // undefined release kind is refused without touching the table
      cin.bad       = (req_mode == MODE_RELEASE) && (req_release_kind != REL_UNLOCK) &&
                      (req_release_kind != REL_SWITCH) && (req_release_kind != REL_RESET);
      full      = (cnt_ff == 2'd2);
      cmd_empty = (cnt_ff == 2'd0);
      do_push   = push && !full;
      do_pop    = cmd_pop && !cmd_empty;
      wp_in     = wp_ff ^ do_push;
      rp_in     = rp_ff ^ do_pop;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
      cmd       = slot_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= cin;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/blm_rsp_fifo.sv */
// Result queue between the engine and the result ports.
`default_nettype none
module blm_rsp_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr,
   input  wire blm_pkg::rsp_type wdata,
   output logic                  wfull,
   input  wire logic             pop,
   output logic                  empty,
   output blm_pkg::rsp_type      rdata
);
   import blm_pkg::*;

   rsp_type    mem_ff [4];
   logic [1:0] wp_ff, rp_ff, wp_in, rp_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       do_wr, do_rd;

   always_comb begin
      wfull  = (cnt_ff == 3'd4);
      empty  = (cnt_ff == 3'd0);
      do_wr  = wr && !wfull;
      do_rd  = pop && !empty;
      wp_in  = wp_ff + {1'b0, do_wr};
      rp_in  = rp_ff + {1'b0, do_rd};
      cnt_in = cnt_ff + {2'b0, do_wr} - {2'b0, do_rd};
      rdata  = mem_ff[rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 2'd0;
         rp_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/blm_engine.sv */
// Lock engine: entry table, waiter queues and the grant sequencer.
`default_nettype none
module blm_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire blm_pkg::cfg_type cfg,
   input  wire logic             cmd_empty,
   input  wire blm_pkg::cmd_type cmd,
   output logic                  cmd_pop,
   input  wire logic             rsp_full,
   output logic                  rsp_push,
   output blm_pkg::rsp_type      rsp
);
   import blm_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_EVAL  = 6'b000100,
      ST_WREAD = 6'b001000,
      ST_WEVAL = 6'b010000,
      ST_FINAL = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   rec_type   wrec_ff, wrec_in;
   rsp_type   pend_ff, pend_in;
   logic      pend_v_ff, pend_v_in;
   logic      hk_ff, hk_in;
   logic [QCNT_W-1:0] i_ff, i_in, i_nx;

   // table storage
   rec_type  rec_mem [ENTRIES];
   logic     valid_ff [ENTRIES];
   rec_type  rd_ff;
   logic     rvalid_ff;
   wait_type wq_mem [ENTRIES*QDEPTH];
   wait_type wq_rd_ff;

   logic     rec_we, wq_we;
   rec_type  rec_wd;
   wait_type wq_wd;
   logic [ENTRY_W+QPTR_W-1:0] wq_wa, wq_ra;

   rec_type cur, nrec;
   logic    kind;
   logic [RC_W-1:0] rc;

   always_comb begin
      cur       = rvalid_ff ? rd_ff : REC_RESET;
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      wrec_in   = wrec_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      hk_in     = hk_ff;
      i_in      = i_ff;
      i_nx      = i_ff + 1'b1;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      rsp       = pend_ff;
      rec_we    = 1'b0;
      rec_wd    = cur;
      wq_we     = 1'b0;
      wq_wd     = '{proc: cmd_ff.requester, kind: 1'b0};
      nrec      = cur;
      kind      = cmd_ff.lock_kind;
      rc        = cur.readers;
      wq_wa     = {cmd_ff.entry, cur.whead + cur.wcount[QPTR_W-1:0]};
      wq_ra     = {cmd_ff.entry, wrec_ff.whead + i_ff[QPTR_W-1:0]};

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (cmd_ff.bad) begin
               rsp = '{kind: R_REJECT, grantee: cmd_ff.requester, entry: cmd_ff.entry,
                       owner: PROC_NONE, last: PROC_NONE, gkind: cmd_ff.lock_kind,
                       last_of_run: 1'b1};
               if (!rsp_full) begin
                  rsp_push = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (cmd_ff.mode == MODE_LOCK) begin
               // migrating read turns exclusive
               if (cfg.mig && kind == K_READ && cur.last == {1'b0, cmd_ff.requester} &&
                   cur.owner != {1'b0, cmd_ff.requester}) begin
                  kind = K_WRITE;
               end
               rsp = '{kind: R_GRANT, grantee: cmd_ff.requester, entry: cmd_ff.entry,
                       owner: cur.owner, last: cur.last, gkind: kind, last_of_run: 1'b1};
               if (cur.owner == PROC_NONE) begin
                  nrec.owner  = {1'b0, cmd_ff.requester};
                  nrec.holder = {1'b0, cmd_ff.requester};
                  nrec.last   = PROC_NONE;
                  nrec.emode  = EM_WRITE;
                  rsp.owner   = PROC_NONE;
                  rsp.last    = PROC_NONE;
                  rsp.gkind   = K_WRITE;
               end else if (cur.holder == PROC_NONE) begin
                  nrec.holder = {1'b0, cmd_ff.requester};
                  nrec.emode  = (kind == K_READ) ? EM_READ : EM_WRITE;
                  if (kind == K_READ && cur.readers != READER_MAX) begin
                     nrec.readers = cur.readers + 1'b1;
                  end
               end else if (cur.emode == EM_READ && kind == K_READ && cur.wcount == '0) begin
                  if (cur.readers != READER_MAX) begin
                     nrec.readers = cur.readers + 1'b1;
                  end
               end else if (cur.wcount >= QFULL) begin
                  rsp.kind = R_REJECT;
               end else begin
                  rsp.kind    = R_QUEUE;
                  wq_wd.kind  = kind;
                  nrec.wcount = cur.wcount + 1'b1;
                  wq_we       = !rsp_full;
               end
               if (!rsp_full) begin
                  rsp_push = 1'b1;
                  rec_we   = 1'b1;
                  rec_wd   = nrec;
                  state_in = ST_IDLE;
               end
            end else begin
               if (cur.emode == EM_READ && cur.readers != '0) begin
                  rc = cur.readers - 1'b1;
               end
               nrec.readers = rc;
               if (cur.emode == EM_READ && rc != '0) begin
                  // other readers still hold the entry
                  rec_we   = 1'b1;
                  rec_wd   = nrec;
                  state_in = ST_IDLE;
               end else if (cur.wcount == '0) begin
                  nrec.holder = PROC_NONE;
                  nrec.last   = {1'b0, cmd_ff.requester};
                  nrec.emode  = EM_FREE;
                  if (cmd_ff.rel_kind == REL_RESET) begin
                     nrec.owner = PROC_NONE;
                     nrec.last  = PROC_NONE;
                  end else if (cmd_ff.rel_kind == REL_SWITCH) begin
                     nrec.owner = {1'b0, cmd_ff.requester};
                  end
                  rec_we   = 1'b1;
                  rec_wd   = nrec;
                  state_in = ST_IDLE;
               end else begin
                  if (cmd_ff.rel_kind == REL_SWITCH) begin
                     nrec.owner = {1'b0, cmd_ff.requester};
                  end
                  wrec_in   = nrec;
                  i_in      = '0;
                  pend_v_in = 1'b0;
                  state_in  = ST_WREAD;
               end
            end
         end
         ST_WREAD: begin
            state_in = ST_WEVAL;
         end
         ST_WEVAL: begin
            if (i_ff == '0 && cmd_ff.rel_kind == REL_RESET) begin
               // evicted block: head alone gets it exclusively
               wrec_in.owner  = {1'b0, wq_rd_ff.proc};
               wrec_in.holder = {1'b0, wq_rd_ff.proc};
               wrec_in.last   = PROC_NONE;
               wrec_in.emode  = EM_WRITE;
               pend_in = '{kind: R_GRANT, grantee: wq_rd_ff.proc, entry: cmd_ff.entry,
                           owner: PROC_NONE, last: PROC_NONE, gkind: K_WRITE,
                           last_of_run: 1'b0};
               pend_v_in = 1'b1;
               i_in      = i_nx;
               state_in  = ST_FINAL;
            end else if (i_ff == '0 || (hk_ff == K_READ && wq_rd_ff.kind == K_READ)) begin
               rsp = pend_ff;
               rsp.last_of_run = 1'b0;
               if (!(pend_v_ff && rsp_full)) begin
                  rsp_push = pend_v_ff;
                  if (i_ff == '0) begin
                     hk_in          = wq_rd_ff.kind;
                     wrec_in.holder = {1'b0, wq_rd_ff.proc};
                     wrec_in.emode  = (wq_rd_ff.kind == K_READ) ? EM_READ : EM_WRITE;
                     wrec_in.last   = {1'b0, cmd_ff.requester};
                  end else if (wq_rd_ff.proc == cfg.my_rank) begin
                     wrec_in.holder = {1'b0, wq_rd_ff.proc};
                  end
                  if (wq_rd_ff.kind == K_READ && wrec_ff.readers != READER_MAX) begin
                     wrec_in.readers = wrec_ff.readers + 1'b1;
                  end
                  pend_in = '{kind: R_GRANT, grantee: wq_rd_ff.proc, entry: cmd_ff.entry,
                              owner: wrec_ff.owner, last: {1'b0, cmd_ff.requester},
                              gkind: wq_rd_ff.kind, last_of_run: 1'b0};
                  pend_v_in = 1'b1;
                  i_in      = i_nx;
                  if (i_nx < wrec_ff.wcount && wq_rd_ff.kind == K_READ) begin
                     state_in = ST_WREAD;
                  end else begin
                     state_in = ST_FINAL;
                  end
               end
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            rsp = pend_ff;
            rsp.last_of_run = 1'b1;
            if (!rsp_full) begin
               rsp_push      = 1'b1;
               pend_v_in     = 1'b0;
               rec_we        = 1'b1;
               rec_wd        = wrec_ff;
               rec_wd.wcount = wrec_ff.wcount - i_ff;
               rec_wd.whead  = wrec_ff.whead + i_ff[QPTR_W-1:0];
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_v_ff <= 1'b0;
         for (int k = 0; k < ENTRIES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         pend_v_ff <= pend_v_in;
         if (rec_we) begin
            valid_ff[cmd_ff.entry] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      wrec_ff <= wrec_in;
      pend_ff <= pend_in;
      hk_ff   <= hk_in;
      i_ff    <= i_in;
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[cmd_ff.entry] <= rec_wd;
      end
      if (state_ff == ST_READ) begin
         rd_ff     <= rec_mem[cmd_ff.entry];
         rvalid_ff <= valid_ff[cmd_ff.entry];
      end
   end

   always_ff @(posedge clock) begin
      if (wq_we) begin
         wq_mem[wq_wa] <= wq_wd;
      end
      if (state_ff == ST_WREAD) begin
         wq_rd_ff <= wq_mem[wq_ra];
      end
   end

   a_final_has_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINAL) |-> pend_v_ff)
      else $error("final step without a pending grant");
   a_slot_in_queue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WEVAL) |-> (i_ff < wrec_ff.wcount))
      else $error("waiter index beyond queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      wq_we |-> (state_ff == ST_EVAL && cmd_ff.mode == MODE_LOCK))
      else $error("waiter write outside lock request");

endmodule
`default_nettype wire

/* rtl/core/block_lock_manager.sv */
// Block lock manager top level: intake, lock engine, result queue, CSRs.
// A lock request's result passes the intake queue, the engine's read and evaluate steps
// and the result queue. A release granting waiters reads them in turn and sends its last
// result from the final step, reading one more waiter when a write waiter ends the run
// of readers; a release with no result only updates the table. The engine takes one
// request at a time, set by its sequencer and the single-port memories, with 2 requests
// buffered ahead. Reset (synchronous): all entries read as free and uncached, queues
// empty, registers zero. Entry valid bits clear at once, no clearing pass.
`default_nettype none
module block_lock_manager (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_mode,
   input  wire logic [5:0]  req_requester,
   input  wire logic [7:0]  req_entry_index,
   input  wire logic        req_lock_kind,
   input  wire logic [1:0]  req_release_kind,
   // result channel
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_result_kind,
   output logic [5:0]       rsp_grantee,
   output logic [7:0]       rsp_entry_seen,
   output logic [6:0]       rsp_owner_seen,
   output logic [6:0]       rsp_last_seen,
   output logic             rsp_granted_kind,
   output logic             rsp_last_of_run,
   // CSR port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import blm_pkg::*;

   localparam logic [2:0] ADDR_MY_RANK   = 3'd0;
   localparam logic [2:0] ADDR_MIGRATION = 3'd4;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_empty, cmd_pop;
   rsp_type rsp_w, rsp_head;
   logic    rsp_push, rsp_full;
   logic    csr_wr;

   // CSR: zero-wait writes on the access phase
   always_comb begin
      pready = 1'b1;
      csr_wr = psel && penable && pwrite;
      cfg_in = cfg_ff;
      if (csr_wr && paddr == ADDR_MY_RANK) begin
         cfg_in.my_rank = pwdata[PROC_W-1:0];
      end
      if (csr_wr && paddr == ADDR_MIGRATION) begin
         cfg_in.mig = pwdata[0];
      end
      prdata = '0;
      if (paddr == ADDR_MY_RANK) begin
         prdata = {26'd0, cfg_ff.my_rank};
      end else if (paddr == ADDR_MIGRATION) begin
         prdata = {31'd0, cfg_ff.mig};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accepts and classifies requests
   blm_front u_front (
      .clock, .reset, .push, .full,
      .req_mode, .req_requester, .req_entry_index, .req_lock_kind, .req_release_kind,
      .cmd_pop, .cmd_empty, .cmd
   );

   // back: table lookup, grant/queue decisions, waiter hand-off
   blm_engine u_engine (
      .clock, .reset, .cfg(cfg_ff), .cmd_empty, .cmd, .cmd_pop,
      .rsp_full, .rsp_push, .rsp(rsp_w)
   );

   // results wait here so the engine keeps going while the consumer stalls
   blm_rsp_fifo u_rsp (
      .clock, .reset, .wr(rsp_push), .wdata(rsp_w), .wfull(rsp_full),
      .pop, .empty, .rdata(rsp_head)
   );

   assign rsp_result_kind  = rsp_head.kind;
   assign rsp_grantee      = rsp_head.grantee;
   assign rsp_entry_seen   = rsp_head.entry;
   assign rsp_owner_seen   = rsp_head.owner;
   assign rsp_last_seen    = rsp_head.last;
   assign rsp_granted_kind = rsp_head.gkind;
   assign rsp_last_of_run  = rsp_head.last_of_run;

endmodule
`default_nettype wire

/* tb/block_lock_manager_test.sv */
// Testbench for the block lock manager: directed and random lock traffic checked against a behavioral model.
`timescale 1ns / 100ps
module block_lock_manager_test;
   import blm_pkg::*;

   typedef struct {
      logic       mode;
      logic [5:0] requester;
      logic [7:0] entry;
      logic       lock_kind;
      logic [1:0] rel_kind;
   } lock_request_type;

   typedef struct {
      logic [1:0] kind;
      logic [5:0] grantee;
      logic [7:0] entry;
      logic [6:0] owner;
      logic [6:0] last;
      logic       gkind;
      logic       last_of_run;
   } lock_result_type;

   logic clock = 0, reset = 1;
   logic push = 0, pop = 0;
   logic req_mode = 0, req_lock_kind = 0;
   logic [5:0] req_requester = 0;
   logic [7:0] req_entry_index = 0;
   logic [1:0] req_release_kind = 0;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [2:0] paddr = 0;
   logic [31:0] pwdata = 0;
   wire full, empty, pready;
   wire [31:0] prdata;
   wire [1:0] rsp_result_kind;
   wire [5:0] rsp_grantee;
   wire [7:0] rsp_entry_seen;
   wire [6:0] rsp_owner_seen, rsp_last_seen;
   wire rsp_granted_kind, rsp_last_of_run;

   block_lock_manager dut (.*);

   // Register addresses (byte offsets)
   localparam logic [2:0] ADDR_MY_RANK = 3'd0;
   localparam logic [2:0] ADDR_MIGRATE = 3'd4;
   // release kind with no meaning, refused by the block
   localparam logic [1:0] REL_UNDEF = 2'd3;

   // Shadow lock table
   logic [6:0] tbl_owner [ENTRIES];
   logic [6:0] tbl_holder [ENTRIES];
   logic [6:0] tbl_last [ENTRIES];
   logic [1:0] tbl_mode [ENTRIES];
   logic [6:0] tbl_readers [ENTRIES];
   int         tbl_waiters [ENTRIES];
   logic [5:0] wq_proc [ENTRIES][QDEPTH];
   logic       wq_kind [ENTRIES][QDEPTH];
   logic [5:0] rank_shadow = 0;
   logic       mig_shadow = 0;

   lock_request_type pending_requests[$];
   lock_result_type  expected_results[$];
   int errors = 0;
   bit hold_start = 0;  // asks the receiver for its long stall
   bit hold_done = 0;
   int hold_off = 0;    // long receiver stall, counted in the receiver

   initial forever #5 clock = ~clock;

   function automatic void push_result(logic [1:0] k, logic [5:0] who, logic [7:0] e,
                                       logic [6:0] own, logic [6:0] lst, logic gk);
      lock_result_type r;
      r.kind = k; r.grantee = who; r.entry = e; r.owner = own; r.last = lst;
      r.gkind = gk; r.last_of_run = 0;
      expected_results.push_back(r);
   endfunction

   function automatic void add_reader(int e);
      if (tbl_readers[e] < READER_MAX) tbl_readers[e]++;
   endfunction

   // Work out the grants/queue outcome for one accepted request
   function automatic void predict_lock_table(lock_request_type q);
      int e, cnt, run, start_size;
      logic k;
      e = q.entry;
      k = q.lock_kind;
      start_size = expected_results.size();
      if (q.mode == MODE_RELEASE && q.rel_kind == REL_UNDEF) begin
         push_result(R_REJECT, q.requester, q.entry, PROC_NONE, PROC_NONE, q.lock_kind);
      end else if (q.mode == MODE_LOCK) begin
         if (mig_shadow && k == K_READ && tbl_last[e] == {1'b0, q.requester} &&
             tbl_owner[e] != {1'b0, q.requester})
            k = K_WRITE;
         if (tbl_owner[e] == PROC_NONE) begin
            tbl_owner[e] = {1'b0, q.requester}; tbl_holder[e] = {1'b0, q.requester};
            tbl_last[e] = PROC_NONE; tbl_mode[e] = EM_WRITE;
            push_result(R_GRANT, q.requester, q.entry, PROC_NONE, PROC_NONE, K_WRITE);
         end else if (tbl_holder[e] == PROC_NONE) begin
            tbl_holder[e] = {1'b0, q.requester};
            tbl_mode[e] = (k == K_READ) ? EM_READ : EM_WRITE;
            if (k == K_READ) add_reader(e);
            push_result(R_GRANT, q.requester, q.entry, tbl_owner[e], tbl_last[e], k);
         end else if (tbl_mode[e] == EM_READ && k == K_READ && tbl_waiters[e] == 0) begin
            add_reader(e);
            push_result(R_GRANT, q.requester, q.entry, tbl_owner[e], tbl_last[e], k);
         end else if (tbl_waiters[e] >= QDEPTH) begin
            push_result(R_REJECT, q.requester, q.entry, tbl_owner[e], tbl_last[e], k);
         end else begin
            wq_proc[e][tbl_waiters[e]] = q.requester;
            wq_kind[e][tbl_waiters[e]] = k;
            tbl_waiters[e]++;
            push_result(R_QUEUE, q.requester, q.entry, tbl_owner[e], tbl_last[e], k);
         end
      end else begin
         cnt = tbl_waiters[e];
         if (tbl_mode[e] == EM_READ) begin
            if (tbl_readers[e] > 0) tbl_readers[e]--;
            if (tbl_readers[e] != 0) return;
         end
         if (cnt == 0) begin
            tbl_holder[e] = PROC_NONE; tbl_last[e] = {1'b0, q.requester};
            tbl_mode[e] = EM_FREE;
            if (q.rel_kind == REL_RESET) begin
               tbl_owner[e] = PROC_NONE; tbl_last[e] = PROC_NONE;
            end else if (q.rel_kind == REL_SWITCH) begin
               tbl_owner[e] = {1'b0, q.requester};
            end
            return;
         end
         if (q.rel_kind == REL_RESET) begin
            tbl_owner[e] = {1'b0, wq_proc[e][0]}; tbl_holder[e] = {1'b0, wq_proc[e][0]};
            tbl_last[e] = PROC_NONE; tbl_mode[e] = EM_WRITE;
            push_result(R_GRANT, wq_proc[e][0], q.entry, PROC_NONE, PROC_NONE, K_WRITE);
            run = 1;
         end else begin
            if (q.rel_kind == REL_SWITCH) tbl_owner[e] = {1'b0, q.requester};
            tbl_holder[e] = {1'b0, wq_proc[e][0]};
            tbl_mode[e] = (wq_kind[e][0] == K_READ) ? EM_READ : EM_WRITE;
            tbl_last[e] = {1'b0, q.requester};
            run = 0;
            while (run < cnt && wq_kind[e][run] == K_READ) run++;
            if (run == 0) run = 1;
            for (int i = 0; i < run; i++) begin
               if (wq_proc[e][i] == rank_shadow) tbl_holder[e] = {1'b0, wq_proc[e][i]};
               push_result(R_GRANT, wq_proc[e][i], q.entry, tbl_owner[e],
                           {1'b0, q.requester}, wq_kind[e][i]);
               if (wq_kind[e][i] == K_READ) add_reader(e);
            end
         end
         for (int i = run; i < cnt; i++) begin
            wq_proc[e][i-run] = wq_proc[e][i];
            wq_kind[e][i-run] = wq_kind[e][i];
         end
         tbl_waiters[e] = cnt - run;
      end
      if (expected_results.size() > start_size)
         expected_results[expected_results.size()-1].last_of_run = 1;
   endfunction

   // Driver: bursts of requests with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (push && !full) begin
            predict_lock_table(pending_requests.pop_front());
         end
         if (!(push && full)) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               push <= 0;
            end else if (pending_requests.size() > 0 && (push && !full ?
                         pending_requests.size() > 0 : 1)) begin
               if (burst_left == 0) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                  push <= 0;
               end else begin
                  burst_left <= burst_left - 1;
                  push <= 1;
                  req_mode <= pending_requests[0].mode;
                  req_requester <= pending_requests[0].requester;
                  req_entry_index <= pending_requests[0].entry;
                  req_lock_kind <= pending_requests[0].lock_kind;
                  req_release_kind <= pending_requests[0].rel_kind;
               end
            end else begin
               push <= 0;
            end
         end
      end
   end

   // Monitor and receiver stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result: grantee %0d entry %0d", rsp_grantee, rsp_entry_seen);
               errors++;
            end else begin
               lock_result_type x;
               x = expected_results.pop_front();
               if (rsp_result_kind !== x.kind) begin
                  $error("result_kind exp %0d got %0d", x.kind, rsp_result_kind); errors++; end
               if (rsp_grantee !== x.grantee) begin
                  $error("grantee exp %0d got %0d", x.grantee, rsp_grantee); errors++; end
               if (rsp_entry_seen !== x.entry) begin
                  $error("entry_seen exp %0d got %0d", x.entry, rsp_entry_seen); errors++; end
               if (rsp_owner_seen !== x.owner) begin
                  $error("owner_seen exp %0d got %0d", x.owner, rsp_owner_seen); errors++; end
               if (rsp_last_seen !== x.last) begin
                  $error("last_seen exp %0d got %0d", x.last, rsp_last_seen); errors++; end
               if (rsp_granted_kind !== x.gkind) begin
                  $error("granted_kind exp %0d got %0d", x.gkind, rsp_granted_kind); errors++; end
               if (rsp_last_of_run !== x.last_of_run) begin
                  $error("last_of_run exp %0d got %0d", x.last_of_run, rsp_last_of_run);
                  errors++;
               end
            end
         end
         stall_phase <= (stall_phase + 1) % 37;
         if (hold_start && !hold_done) begin
            hold_done <= 1;
            hold_off <= 300;
            pop <= 0;
         end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= 0;
         end else if (stall_phase < 12) begin
            pop <= 1;   // stretch with no stalls
         end else begin
            pop <= ($urandom_range(0, 2) != 0);
         end
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] value);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == ADDR_MY_RANK) rank_shadow = value[5:0];
      else mig_shadow = value[0];
   endtask

   task automatic queue_request(logic m, logic [5:0] r, logic [7:0] e, logic k, logic [1:0] rk);
      lock_request_type q;
      q.mode = m; q.requester = r; q.entry = e; q.lock_kind = k; q.rel_kind = rk;
      pending_requests.push_back(q);
   endtask

   task automatic drain_to_idle();
      while (pending_requests.size() > 0 || push || expected_results.size() > 0)
         @(posedge clock);
      repeat (30) @(posedge clock);   // releases with no result may still be in flight
   endtask

   // Random traffic, mostly on four hot entries, so queues fill and drain
   task automatic random_phase(int count);
      logic [7:0] hot [4];
      for (int i = 0; i < 4; i++) hot[i] = 8'($urandom_range(0, 255));
      for (int i = 0; i < count; i++) begin
         int sel;
         logic [7:0] e;
         sel = $urandom_range(0, 99);
         e = (sel < 85) ? hot[$urandom_range(0, 3)] : 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 55)
            queue_request(MODE_LOCK, 6'($urandom_range(0, 63)), e, 1'($urandom_range(0, 1)),
                          2'($urandom_range(0, 3)));
         else
            queue_request(MODE_RELEASE, 6'($urandom_range(0, 63)), e,
                          1'($urandom_range(0, 1)),
                          ($urandom_range(0, 19) == 0) ? REL_UNDEF : 2'($urandom_range(0, 2)));
      end
   endtask

   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         tbl_owner[i] = PROC_NONE; tbl_holder[i] = PROC_NONE; tbl_last[i] = PROC_NONE;
         tbl_mode[i] = EM_FREE; tbl_readers[i] = 0; tbl_waiters[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      csr_write(ADDR_MY_RANK, 32'd0);
      csr_write(ADDR_MIGRATE, 32'd0);

      // Directed: uncached grant, shared readers, queued waiters, undefined release kind
      queue_request(MODE_LOCK, 6'd0, 8'd0, K_READ, REL_UNLOCK);
      queue_request(MODE_LOCK, 6'd63, 8'd255, K_WRITE, REL_UNDEF);
      queue_request(MODE_RELEASE, 6'd0, 8'd0, K_READ, REL_UNLOCK);   // frees entry
      queue_request(MODE_LOCK, 6'd5, 8'd0, K_READ, REL_UNLOCK);      // free, read grant
      queue_request(MODE_LOCK, 6'd6, 8'd0, K_READ, REL_UNLOCK);      // shared grant
      for (int i = 0; i < 9; i++)                                    // 2 shared, 7 queued
         queue_request(MODE_LOCK, 6'(10 + i), 8'd0, (i % 3 == 2), REL_UNLOCK);
      queue_request(MODE_RELEASE, 6'd5, 8'd0, K_READ, REL_UNLOCK);   // reader drop, no result
      queue_request(MODE_RELEASE, 6'd6, 8'd0, K_READ, REL_SWITCH);   // reader drop, readers remain
      queue_request(MODE_RELEASE, 6'd12, 8'd0, K_WRITE, REL_RESET);  // reader drop, readers remain
      queue_request(MODE_RELEASE, 6'd13, 8'd0, K_READ, REL_UNDEF);   // undefined kind
      queue_request(MODE_RELEASE, 6'd63, 8'd200, K_WRITE, REL_RESET);// release free entry
      queue_request(MODE_LOCK, 6'd1, 8'd200, K_WRITE, REL_UNLOCK);
      drain_to_idle();

      // Long receiver hold-off while requests keep coming: block fills up
      hold_start = 1;
      random_phase(40);
      drain_to_idle();

      // Migration on, rank at the top end; last releaser rereads
      csr_write(ADDR_MY_RANK, 32'd63);
      csr_write(ADDR_MIGRATE, 32'd1);
      queue_request(MODE_LOCK, 6'd20, 8'd7, K_WRITE, REL_UNLOCK);
      queue_request(MODE_RELEASE, 6'd20, 8'd7, K_WRITE, REL_SWITCH);
      queue_request(MODE_LOCK, 6'd21, 8'd7, K_READ, REL_UNLOCK);
      queue_request(MODE_RELEASE, 6'd21, 8'd7, K_READ, REL_UNLOCK);
      queue_request(MODE_LOCK, 6'd21, 8'd7, K_READ, REL_UNLOCK);     // promoted
      random_phase(150);
      drain_to_idle();

      csr_write(ADDR_MY_RANK, $urandom_range(0, 63));
      csr_write(ADDR_MIGRATE, 32'd0);
      random_phase(200);
      drain_to_idle();

      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end
endmodule

/* sim.f */
rtl/core/blm_pkg.sv
rtl/core/blm_front.sv
rtl/core/blm_rsp_fifo.sv
rtl/core/blm_engine.sv
rtl/core/block_lock_manager.sv
tb/block_lock_manager_test.sv
